FILE: src/co2fr_pkg.sv
package co2fr_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] ECHO_BYTE  = 8'h86;

  // frame positions
  localparam logic [3:0] POS_START = 4'd0;
  localparam logic [3:0] POS_ECHO  = 4'd1;
  localparam logic [3:0] POS_HIGH  = 4'd2;
  localparam logic [3:0] POS_LOW   = 4'd3;
  localparam logic [3:0] FRAME_LEN = 4'd9;
  localparam logic [3:0] POS_CHECK = FRAME_LEN - 4'd1;

  // one held byte word between input stage and parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_word_t;

endpackage

FILE: src/co2_sensor_frame_receiver.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+--------------------------------
// in      | input     | in_valid/in_stall  | rx_byte[7:0], one frame byte
// out     | output    | out_valid/out_stall| concentration_ppm[15:0]
//
// One word per cycle sustained while the output is not stalled. A byte is
// registered in the input register, then the parser updates frame state and
// loads the result register in the same cycle. Synchronous reset clears
// frame position, sums and valids.
// A stalled result blocks the parser, which then backs up the input register;
// in_stall rises only when that register is full and cannot drain.
module co2_sensor_frame_receiver
  import co2fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] concentration_ppm
);

  byte_word_t held;
  logic       take;

  // input register: parts the upstream handshake from the parser
  co2fr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (take),
    .held     (held)
  );

  // header check, checksum, concentration capture, result register
  co2fr_parse u_parse (
    .clk               (clk),
    .rst               (rst),
    .held              (held),
    .take              (take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .concentration_ppm (concentration_ppm)
  );

endmodule

FILE: src/co2fr_in_stage.sv
module co2fr_in_stage
  import co2fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output byte_word_t held
);

  byte_word_t held_next;

  // full and not drained this cycle
  assign in_stall = held.valid && !take;

  always_comb begin
    held_next = held;
    if (in_valid && !in_stall) begin
      held_next.valid = 1'b1;
      held_next.data  = rx_byte;
    end else if (take) begin
      held_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else begin
      held.valid <= held_next.valid;
    end
    held.data <= held_next.data;
  end

endmodule

FILE: src/co2fr_parse.sv
module co2fr_parse
  import co2fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  byte_word_t  held,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] concentration_ppm
);

  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  first_byte_seen, first_byte_seen_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  concentration_high, concentration_high_next;
  logic [7:0]  concentration_low, concentration_low_next;
  logic        out_ready;
  logic        hit;
  logic [7:0]  b;

  assign out_ready = !out_valid || !out_stall;
  assign take      = held.valid && out_ready;
  assign b         = held.data;

  always_comb begin
    byte_position_next      = byte_position;
    first_byte_seen_next    = first_byte_seen;
    running_sum_next        = running_sum;
    concentration_high_next = concentration_high;
    concentration_low_next  = concentration_low;
    hit                     = 1'b0;
    if (take) begin
      priority if (byte_position == POS_START || byte_position >= FRAME_LEN) begin
        first_byte_seen_next = b;
        byte_position_next   = POS_ECHO;
      end else if (byte_position == POS_ECHO) begin
        if (first_byte_seen != START_BYTE || b != ECHO_BYTE) begin
          // bad header: drop the pair, start over
          byte_position_next      = POS_START;
          first_byte_seen_next    = 8'd0;
          running_sum_next        = 8'd0;
          concentration_high_next = 8'd0;
          concentration_low_next  = 8'd0;
        end else begin
          running_sum_next   = b;
          byte_position_next = POS_HIGH;
        end
      end else if (byte_position == POS_CHECK) begin
        byte_position_next = POS_START;
        hit = ((~running_sum) + 8'd1) == b;
      end else begin
        if (byte_position == POS_HIGH) begin
          concentration_high_next = b;
        end else if (byte_position == POS_LOW) begin
          concentration_low_next = b;
        end
        running_sum_next   = running_sum + b;
        byte_position_next = byte_position + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= POS_START;
      first_byte_seen    <= 8'd0;
      running_sum        <= 8'd0;
      concentration_high <= 8'd0;
      concentration_low  <= 8'd0;
      out_valid          <= 1'b0;
    end else begin
      byte_position      <= byte_position_next;
      first_byte_seen    <= first_byte_seen_next;
      running_sum        <= running_sum_next;
      concentration_high <= concentration_high_next;
      concentration_low  <= concentration_low_next;
      if (out_ready) begin
        out_valid <= hit;
      end
    end
    if (out_ready && hit) begin
      concentration_ppm <= {concentration_high, concentration_low};
    end
  end

endmodule

FILE: test/co2_sensor_frame_receiver_tb.sv
module co2_sensor_frame_receiver_tb
  import co2fr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Clock and reset: 20 ns period, reset asserted at the start only.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT ports. Every input starts at a known value.
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] concentration_ppm;

  co2_sensor_frame_receiver dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .concentration_ppm (concentration_ppm)
  );

  // ---------------------------------------------------------------------------
  // Shared state of the bench
  // ---------------------------------------------------------------------------
  int send_idle_pct = 0;    // chance (of 100) that the sender leaves a gap
  int stall_pct     = 0;    // chance (of 100) that the receiver stalls a cycle
  int hold_request  = 0;    // long receiver hold-off, in cycles; 0 = none
  int hold_left     = 0;    // owned by the stall process
  int mismatches    = 0;
  int words_sent    = 0;

  // Frame tracker: mirror of the parser state, updated per accepted word.
  logic [3:0]  frame_pos = POS_START;
  logic [7:0]  lead_byte = 8'h00;
  logic [7:0]  byte_sum  = 8'h00;
  logic [7:0]  ppm_high  = 8'h00;
  logic [7:0]  ppm_low   = 8'h00;
  logic [15:0] pending_ppm[$];   // concentrations still owed by the DUT
  logic [15:0] ppm_wanted;

  // Follows one accepted frame byte; queues a concentration when the
  // checksum byte closes a frame whose checksum matches.
  task automatic track_frame_byte(input logic [7:0] b);
    logic [7:0] sum_check;
    if (frame_pos == POS_START || frame_pos >= FRAME_LEN) begin
      // start of a frame (an out-of-range position also restarts here)
      lead_byte = b;
      frame_pos = POS_ECHO;
    end else if (frame_pos == POS_ECHO) begin
      if (lead_byte != START_BYTE || b != ECHO_BYTE) begin
        // bad header: drop the pair, no search for a start byte inside it
        frame_pos = POS_START;
        lead_byte = 8'h00;
        byte_sum  = 8'h00;
        ppm_high  = 8'h00;
        ppm_low   = 8'h00;
      end else begin
        byte_sum  = b;
        frame_pos = POS_HIGH;
      end
    end else if (frame_pos == POS_CHECK) begin
      frame_pos = POS_START;
      sum_check = ~byte_sum + 8'd1;
      if (sum_check == b) pending_ppm.push_back({ppm_high, ppm_low});
    end else begin
      if (frame_pos == POS_HIGH) ppm_high = b;
      else if (frame_pos == POS_LOW) ppm_low = b;
      byte_sum  = byte_sum + b;
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Called right after a rising edge. Valid is only lowered when a
  // gap is taken, so it never drops and rises again within one time step.
  // in_stall is sampled at the falling edge, clear of the rising-edge updates.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    bit stalled;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    track_frame_byte(b);
    words_sent++;
  endtask

  // Full 9-byte frame; filler bytes 4..7 are random. bad_sum corrupts the
  // checksum byte by a nonzero xor, so the frame must yield no result.
  task automatic send_frame(input logic [15:0] ppm, input bit bad_sum);
    logic [7:0] body[1:7];
    logic [7:0] sum;
    body[1] = ECHO_BYTE;
    body[2] = ppm[15:8];
    body[3] = ppm[7:0];
    for (int i = 4; i <= 7; i++) body[i] = 8'($urandom_range(255));
    sum = 8'h00;
    for (int i = 1; i <= 7; i++) sum = sum + body[i];
    sum = ~sum + 8'd1;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(START_BYTE);
    for (int i = 1; i <= 7; i++) send_byte(body[i]);
    send_byte(sum);
  endtask

  // Sender goes quiet until every owed concentration has come out, then lets
  // the pipeline settle.
  task automatic wait_results_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_ppm.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_ppm.size() != 0) begin
      $error("concentration_ppm: %0d expected results never arrived", pending_ppm.size());
      mismatches++;
      pending_ppm.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, or a long hold-off when one is requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request > 0) begin
      out_stall    <= 1'b1;
      hold_left    <= hold_request - 1;
      hold_request = 0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: at the falling edge, valid and stall hold the values seen
  // at the next rising edge, so a word seen here is the one accepted there.
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_ppm.size() == 0) begin
        $error("concentration_ppm: expected none, actual %0d", concentration_ppm);
        mismatches++;
      end else begin
        ppm_wanted = pending_ppm.pop_front();
        if (concentration_ppm !== ppm_wanted) begin
          $error("concentration_ppm: expected %0d, actual %0d", ppm_wanted,
                 concentration_ppm);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header and checksum corner cases with extreme byte values.
  task automatic test_header_and_checksum();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_frame(16'hFFFF, 1'b0);        // largest reading
    send_byte(8'h00);                  // wrong start byte, right echo
    send_byte(ECHO_BYTE);
    send_byte(START_BYTE);             // right start byte, wrong echo
    send_byte(8'h00);
    send_byte(START_BYTE);             // start byte repeated: pair is bad,
    send_byte(START_BYTE);             // no realignment onto the second one
    send_frame(16'h0000, 1'b1);        // zero reading, checksum off
    send_frame(16'h0000, 1'b0);        // zero reading, checksum good
    wait_results_drained();
  endtask

  // Mostly well-formed frames with random content; the rest bad checksums,
  // broken headers and stray bytes that knock the framing out of line.
  task automatic test_random_frames(input int n_words, input int idle, input int stall);
    int start_count;
    int pick;
    logic [15:0] ppm;
    send_idle_pct = idle;
    stall_pct     = stall;
    start_count   = words_sent;
    while (words_sent - start_count < n_words) begin
      pick = $urandom_range(99);
      case ($urandom_range(7))
        0:       ppm = 16'h0000;
        1:       ppm = 16'hFFFF;
        default: ppm = 16'($urandom_range(16'hFFFF));
      endcase
      if (pick < 78) begin
        send_frame(ppm, 1'b0);
      end else if (pick < 88) begin
        send_frame(ppm, 1'b1);
      end else if (pick < 96) begin
        // broken header; now and then it happens to be a valid one
        send_byte($urandom_range(1) ? START_BYTE : 8'($urandom_range(255)));
        send_byte($urandom_range(1) ? ECHO_BYTE : 8'($urandom_range(255)));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    wait_results_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering frames, so the DUT
  // backs up and stalls its input; a drain pause follows, then a round with random stalls.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 80;
    for (int i = 0; i < 6; i++) send_frame(16'($urandom_range(16'hFFFF)), 1'b0);
    wait_results_drained();
    stall_pct = 30;
    for (int i = 0; i < 6; i++) send_frame(16'($urandom_range(16'hFFFF)), 1'b0);
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_and_checksum();
    test_random_frames(240, 0, 0);
    test_random_frames(240, 61, 0);
    test_random_frames(240, 0, 61);
    test_random_frames(240, 19, 19);
    test_output_holdoff();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~1100 words, heavy stalls).
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: co2_sensor_frame_receiver.f
src/co2fr_pkg.sv
src/co2fr_in_stage.sv
src/co2fr_parse.sv
src/co2_sensor_frame_receiver.sv
test/co2_sensor_frame_receiver_tb.sv
